@@ hdl/bds_pkg.sv @@
package bds_pkg;

	localparam int MAX_OUT_WIDTH = 1024;
	localparam int IDX_W = $clog2(MAX_OUT_WIDTH);

	localparam int CH_W = 8;
	localparam int SUM_W = CH_W + 1;
	localparam int COL_W = 10;
	localparam int ROW_W = 11;
	localparam int CCNT_W = COL_W + 1;
	localparam int RCNT_W = ROW_W + 1;
	localparam int WIDTH_W = 12;
	localparam int HEIGHT_W = 13;

	localparam logic [WIDTH_W-1:0] W_MIN = WIDTH_W'(2);
	localparam logic [WIDTH_W-1:0] W_MAX = WIDTH_W'(2 * MAX_OUT_WIDTH);
	localparam logic [HEIGHT_W-1:0] H_MIN = HEIGHT_W'(2);
	localparam logic [HEIGHT_W-1:0] H_MAX = HEIGHT_W'(4096);
	localparam logic [WIDTH_W-1:0] W_RESET = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] H_RESET = HEIGHT_W'(480);

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = HEIGHT_W;
	localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT = CFG_IDX_W'(1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	typedef struct packed {
		logic [SUM_W-1:0] b;
		logic [SUM_W-1:0] g;
		logic [SUM_W-1:0] r;
	} pair_t;

	// emit: odd row, read the line store and produce a result
	// otherwise: even row, store the pair sum
	typedef struct packed {
		logic             emit;
		logic [IDX_W-1:0] idx;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last;
		pair_t            pair;
	} op_t;

endpackage

@@ hdl/bds_front.sv @@
module bds_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bds_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bds_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bds_pkg::CH_W-1:0]       in_red,
	input  logic [bds_pkg::CH_W-1:0]       in_green,
	input  logic [bds_pkg::CH_W-1:0]       in_blue,
	input  logic                          q_full,
	output logic                          push,
	output bds_pkg::op_t                  push_op
);
	import bds_pkg::*;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [CCNT_W-1:0]   col_q;
	logic [RCNT_W-1:0]   row_q;
	pair_t               held_q;

	logic [WIDTH_W-1:0]  w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic [WIDTH_W-2:0]  out_w;
	logic [HEIGHT_W-2:0] out_h;
	logic [COL_W-1:0]    oc;
	logic [ROW_W-1:0]    orow;
	logic                in_block;
	logic                in_fire;
	logic                col_end;
	logic                row_end;
	pair_t               pix;
	pair_t               pair_sum;

	assign cfg_ready = 1'b1;
	assign in_ready = !q_full;
	assign in_fire = in_valid && in_ready;

	always_comb begin
		if (width_q < W_MIN)
			w_eff = W_MIN;
		else if (width_q > W_MAX)
			w_eff = W_MAX;
		else
			w_eff = width_q;
		if (height_q < H_MIN)
			h_eff = H_MIN;
		else if (height_q > H_MAX)
			h_eff = H_MAX;
		else
			h_eff = height_q;
	end

	assign out_w = w_eff[WIDTH_W-1:1];
	assign out_h = h_eff[HEIGHT_W-1:1];
	assign oc = col_q[CCNT_W-1:1];
	assign orow = row_q[RCNT_W-1:1];
	assign in_block = ((WIDTH_W-1)'(oc) < out_w) && ((HEIGHT_W-1)'(orow) < out_h);
	assign col_end = (WIDTH_W'(col_q) + WIDTH_W'(1)) >= w_eff;
	assign row_end = (HEIGHT_W'(row_q) + HEIGHT_W'(1)) >= h_eff;

	assign pix.r = SUM_W'(in_red);
	assign pix.g = SUM_W'(in_green);
	assign pix.b = SUM_W'(in_blue);
	assign pair_sum.r = held_q.r + pix.r;
	assign pair_sum.g = held_q.g + pix.g;
	assign pair_sum.b = held_q.b + pix.b;

	// a pair completes on the odd column of a block
	assign push = in_fire && in_block && col_q[0];

	always_comb begin
		push_op.emit = row_q[0];
		push_op.idx = (int'(oc) >= MAX_OUT_WIDTH) ? IDX_W'(MAX_OUT_WIDTH - 1) : IDX_W'(oc);
		push_op.col = oc;
		push_op.row = orow;
		push_op.last = (((WIDTH_W-1)'(oc) + (WIDTH_W-1)'(1)) == out_w)
			&& (((HEIGHT_W-1)'(orow) + (HEIGHT_W-1)'(1)) == out_h);
		push_op.pair = pair_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= W_RESET;
			height_q <= H_RESET;
			col_q <= '0;
			row_q <= '0;
			held_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_IN_WIDTH: width_q <= cfg_data[WIDTH_W-1:0];
					CFG_IN_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
					default: ;
				endcase
			end
			if (in_fire) begin
				if (in_block && !col_q[0])
					held_q <= pix;
				if (col_end) begin
					col_q <= '0;
					if (row_end)
						row_q <= '0;
					else
						row_q <= row_q + RCNT_W'(1);
				end else begin
					col_q <= col_q + CCNT_W'(1);
				end
			end
		end
	end

endmodule

@@ hdl/bds_queue.sv @@
module bds_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  bds_pkg::op_t push_op,
	output logic         full,
	input  logic         pop,
	output logic         head_valid,
	output bds_pkg::op_t head_op
);
	import bds_pkg::*;

	op_t               slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_op = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

@@ hdl/bds_back.sv @@
module bds_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     head_valid,
	input  bds_pkg::op_t             head_op,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [bds_pkg::CH_W-1:0]  out_red,
	output logic [bds_pkg::CH_W-1:0]  out_green,
	output logic [bds_pkg::CH_W-1:0]  out_blue,
	output logic [bds_pkg::COL_W-1:0] out_col,
	output logic [bds_pkg::ROW_W-1:0] out_row,
	output logic                     out_last
);
	import bds_pkg::*;

	pair_t             line_mem [MAX_OUT_WIDTH];
	pair_t             above_s1;
	pair_t             pair_s1;
	logic [COL_W-1:0]  col_s1;
	logic [ROW_W-1:0]  row_s1;
	logic              last_s1;
	logic              valid_s1;
	logic              advance;
	logic              s1_free;
	logic [SUM_W:0]    sum_r;
	logic [SUM_W:0]    sum_g;
	logic [SUM_W:0]    sum_b;

	assign advance = valid_s1 && (!out_valid || out_ready);
	assign s1_free = !valid_s1 || advance;
	// stores go ahead even while a result is stalled
	assign pop = head_valid && (!head_op.emit || s1_free);

	always_ff @(posedge clk) begin
		if (pop && !head_op.emit)
			line_mem[head_op.idx] <= head_op.pair;
		if (pop && head_op.emit) begin
			above_s1 <= line_mem[head_op.idx];
			pair_s1 <= head_op.pair;
			col_s1 <= head_op.col;
			row_s1 <= head_op.row;
			last_s1 <= head_op.last;
		end
	end

	assign sum_r = (SUM_W+1)'(above_s1.r) + (SUM_W+1)'(pair_s1.r);
	assign sum_g = (SUM_W+1)'(above_s1.g) + (SUM_W+1)'(pair_s1.g);
	assign sum_b = (SUM_W+1)'(above_s1.b) + (SUM_W+1)'(pair_s1.b);

	always_ff @(posedge clk) begin
		if (advance) begin
			out_red <= sum_r[SUM_W:2];
			out_green <= sum_g[SUM_W:2];
			out_blue <= sum_b[SUM_W:2];
			out_col <= col_s1;
			out_row <= row_s1;
			out_last <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (pop && head_op.emit)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

endmodule

@@ hdl/box_downsample_2x2.sv @@
// the completing pixel's pair sum passes a queue slot, stage s1 and the output register on its way to out_valid
// throughput: one pixel per cycle, held off only while the four-entry queue is full
// only the odd-row, odd-column pixel of a block makes a result; a pixel pair needs one
// line store access, so the single store port keeps pace with the input
// reset: counters, pending pair sum and queue clear, width 640, height 480;
// the line store is not cleared and holds no data until an even row writes it
module box_downsample_2x2 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bds_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bds_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bds_pkg::CH_W-1:0]       in_red,
	input  logic [bds_pkg::CH_W-1:0]       in_green,
	input  logic [bds_pkg::CH_W-1:0]       in_blue,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bds_pkg::CH_W-1:0]       out_red,
	output logic [bds_pkg::CH_W-1:0]       out_green,
	output logic [bds_pkg::CH_W-1:0]       out_blue,
	output logic [bds_pkg::COL_W-1:0]      out_col,
	output logic [bds_pkg::ROW_W-1:0]      out_row,
	output logic                          out_last
);
	import bds_pkg::*;

	logic q_full;
	logic push;
	op_t  push_op;
	logic pop;
	logic head_valid;
	op_t  head_op;

	bds_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.q_full    (q_full),
		.push      (push),
		.push_op   (push_op)
	);

	bds_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_op    (head_op)
	);

	bds_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_op    (head_op),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.out_col    (out_col),
		.out_row    (out_row),
		.out_last   (out_last)
	);

endmodule

@@ hdl/bds_checker.sv @@
module bds_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [bds_pkg::CH_W-1:0]       out_red,
	input logic [bds_pkg::CH_W-1:0]       out_green,
	input logic [bds_pkg::CH_W-1:0]       out_blue,
	input logic [bds_pkg::COL_W-1:0]      out_col,
	input logic [bds_pkg::ROW_W-1:0]      out_row,
	input logic                          out_last
);
	import bds_pkg::*;

	localparam int DIFF_W = 16;

	logic [DIFF_W-1:0] diff_q;
	logic              in_fire;
	logic              out_fire;

	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// items in minus results out, sticky once saturated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_q <= '0;
		end else if (diff_q != {DIFF_W{1'b1}}) begin
			if (in_fire && !out_fire)
				diff_q <= diff_q + DIFF_W'(1);
			else if (out_fire && !in_fire)
				diff_q <= diff_q - DIFF_W'(1);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
			&& $stable(out_blue) && $stable(out_col) && $stable(out_row)
			&& $stable(out_last))
		else $error("stalled result changed");

	a_result_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> diff_q != '0)
		else $error("result without an accepted item behind it");

	a_cfg_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid || $past(!arst_n) == 1'b0)
		else $error("result shown right after reset");

endmodule

bind box_downsample_2x2 bds_checker u_bds_checker (.*);

@@ dv/box_downsample_2x2_tb.sv @@
`timescale 1ns / 1ps

typedef struct {
	logic [bds_pkg::CH_W-1:0]  red;
	logic [bds_pkg::CH_W-1:0]  green;
	logic [bds_pkg::CH_W-1:0]  blue;
	logic [bds_pkg::COL_W-1:0] col;
	logic [bds_pkg::ROW_W-1:0] row;
	logic                      last;
} pixel_mean_t;

class mean_scoreboard;
	bds_pkg::pair_t row_sums[bds_pkg::MAX_OUT_WIDTH];
	bds_pkg::pair_t left_pair;
	int col_pos;
	int row_pos;
	logic [bds_pkg::WIDTH_W-1:0] width_reg;
	logic [bds_pkg::HEIGHT_W-1:0] height_reg;
	pixel_mean_t expected_means[$];
	int mismatches;

	function new();
		left_pair = '0;
		col_pos = 0;
		row_pos = 0;
		width_reg = bds_pkg::W_RESET;
		height_reg = bds_pkg::H_RESET;
		mismatches = 0;
	endfunction

	function void set_reg(logic [bds_pkg::CFG_IDX_W-1:0] idx,
			logic [bds_pkg::CFG_DATA_W-1:0] data);
		if (idx == bds_pkg::CFG_IN_WIDTH) begin
			width_reg = data[bds_pkg::WIDTH_W-1:0];
		end else if (idx == bds_pkg::CFG_IN_HEIGHT) begin
			height_reg = data;
		end
	endfunction

	function int pending();
		return expected_means.size();
	endfunction

	function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int w;
		int h;
		int oc;
		int orow;
		bds_pkg::pair_t sum;
		bds_pkg::pair_t above;
		pixel_mean_t m;
		w = width_reg;
		h = height_reg;
		if (w < 2) w = 2;
		if (w > 2 * bds_pkg::MAX_OUT_WIDTH) w = 2 * bds_pkg::MAX_OUT_WIDTH;
		if (h < 2) h = 2;
		if (h > 4096) h = 4096;
		oc = col_pos / 2;
		orow = row_pos / 2;
		if (oc < w / 2 && orow < h / 2) begin
			if (col_pos % 2 == 0) begin
				left_pair.r = r;
				left_pair.g = g;
				left_pair.b = b;
			end else begin
				sum.r = left_pair.r + r;
				sum.g = left_pair.g + g;
				sum.b = left_pair.b + b;
				if (row_pos % 2 == 0) begin
					row_sums[oc] = sum;
				end else begin
					above = row_sums[oc];
					m.red = 8'((int'(above.r) + int'(sum.r)) / 4);
					m.green = 8'((int'(above.g) + int'(sum.g)) / 4);
					m.blue = 8'((int'(above.b) + int'(sum.b)) / 4);
					m.col = oc[bds_pkg::COL_W-1:0];
					m.row = orow[bds_pkg::ROW_W-1:0];
					m.last = (oc + 1 == w / 2) && (orow + 1 == h / 2);
					expected_means.push_back(m);
				end
			end
		end
		// counters run on past a shrunk frame and end the line or frame at once
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
	endfunction

	function void check_mean(pixel_mean_t got);
		pixel_mean_t want;
		if (expected_means.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected item: r=%0d g=%0d b=%0d col=%0d row=%0d last=%0d",
					got.red, got.green, got.blue, got.col, got.row, got.last);
			return;
		end
		want = expected_means.pop_front();
		if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
				got.col !== want.col || got.row !== want.row || got.last !== want.last) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch: expected r=%0d g=%0d b=%0d col=%0d row=%0d last=%0d",
					want.red, want.green, want.blue, want.col, want.row, want.last);
				$display("          actual   r=%0d g=%0d b=%0d col=%0d row=%0d last=%0d",
					got.red, got.green, got.blue, got.col, got.row, got.last);
			end
		end
	endfunction
endclass

module box_downsample_2x2_tb;
	import bds_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [CH_W-1:0] in_red;
	logic [CH_W-1:0] in_green;
	logic [CH_W-1:0] in_blue;
	logic out_valid;
	logic out_ready;
	logic [CH_W-1:0] out_red;
	logic [CH_W-1:0] out_green;
	logic [CH_W-1:0] out_blue;
	logic [COL_W-1:0] out_col;
	logic [ROW_W-1:0] out_row;
	logic out_last;

	int send_idle_pct = 0;
	int stall_pct = 0;
	mean_scoreboard board = new();

	box_downsample_2x2 dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_red(in_red),
		.in_green(in_green),
		.in_blue(in_blue),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_red(out_red),
		.out_green(out_green),
		.out_blue(out_blue),
		.out_col(out_col),
		.out_row(out_row),
		.out_last(out_last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// values are stable between edges, so the negedge tells what the next edge takes
	always @(negedge clk) begin
		pixel_mean_t got;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			got.red = out_red;
			got.green = out_green;
			got.blue = out_blue;
			got.col = out_col;
			got.row = out_row;
			got.last = out_last;
			board.check_mean(got);
		end
	end

	initial begin
		#5000000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_red <= r;
		in_green <= g;
		in_blue <= b;
		@(negedge clk);
		while (in_ready !== 1'b1) @(negedge clk);
		board.note_pixel(r, g, b);
		@(posedge clk);
	endtask

	task automatic run_pixels(input int n);
		repeat (n) push_pixel(rand_chan(), rand_chan(), rand_chan());
	endtask

	task automatic run_to(input int row, input int col);
		do push_pixel(rand_chan(), rand_chan(), rand_chan());
		while (!(board.row_pos == row && board.col_pos == col));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		while (cfg_ready !== 1'b1) @(negedge clk);
		board.set_reg(idx, data);
		@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// even-row pixels make no item, so allow the pipeline to settle past the last one
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_mode(input int mode);
		case (mode)
			0: begin send_idle_pct = 0; stall_pct = 0; end
			1: begin send_idle_pct = 69; stall_pct = 0; end
			2: begin send_idle_pct = 0; stall_pct = 69; end
			default: begin send_idle_pct = 22; stall_pct = 22; end
		endcase
	endtask

	// no wider than the first row, so every line entry read was written before
	function automatic logic [CFG_DATA_W-1:0] pick_width();
		case ($urandom_range(9))
			0: return CFG_DATA_W'(0);
			1: return CFG_DATA_W'(1);
			2: return {1'b1, 12'd3};
			3: return CFG_DATA_W'(640);
			default: return {1'($urandom_range(1)), 12'($urandom_range(2, 24))};
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_height();
		case ($urandom_range(9))
			0: return CFG_DATA_W'(0);
			1: return CFG_DATA_W'(1);
			2: return CFG_DATA_W'($urandom_range(4097, 8191));
			default: return CFG_DATA_W'($urandom_range(2, 9));
		endcase
	endfunction

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_IN_WIDTH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		in_red <= '0;
		in_green <= '0;
		in_blue <= '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: a full row of 640, then the start of the next
		set_mode(2);
		run_to(1, 48);
		drain();

		// width and height above their maximum clamp to 2048 and 4096
		set_mode(3);
		write_reg(CFG_IN_WIDTH, CFG_DATA_W'(13'h1FFF));
		write_reg(CFG_IN_HEIGHT, CFG_DATA_W'(13'h1FFF));
		run_pixels(64);
		drain();

		// trailing odd column and row; the cut frame ends first
		write_reg(CFG_IN_WIDTH, CFG_DATA_W'(3));
		write_reg(CFG_IN_HEIGHT, CFG_DATA_W'(3));
		run_to(0, 0);
		push_pixel(8'd255, 8'd255, 8'd255);
		push_pixel(8'd255, 8'd255, 8'd255);
		push_pixel(8'd0, 8'd17, 8'd99);
		push_pixel(8'd255, 8'd255, 8'd255);
		push_pixel(8'd255, 8'd255, 8'd255);
		push_pixel(8'd1, 8'd2, 8'd3);
		push_pixel(8'd200, 8'd0, 8'd255);
		push_pixel(8'd7, 8'd128, 8'd64);
		push_pixel(8'd255, 8'd0, 8'd255);
		drain();

		// both registers below their minimum clamp to 2x2
		write_reg(CFG_IN_WIDTH, CFG_DATA_W'(0));
		write_reg(CFG_IN_HEIGHT, CFG_DATA_W'(1));
		write_reg(CFG_UNUSED, CFG_DATA_W'(13'h1555));
		push_pixel(8'd0, 8'd0, 8'd0);
		push_pixel(8'd0, 8'd0, 8'd0);
		push_pixel(8'd0, 8'd0, 8'd0);
		push_pixel(8'd0, 8'd0, 8'd0);
		// truncation of the mean
		push_pixel(8'd1, 8'd255, 8'd128);
		push_pixel(8'd1, 8'd254, 8'd127);
		push_pixel(8'd1, 8'd255, 8'd128);
		push_pixel(8'd0, 8'd255, 8'd128);
		push_pixel(8'h55, 8'hAA, 8'h55);
		push_pixel(8'hAA, 8'h55, 8'hAA);
		push_pixel(8'hAA, 8'h55, 8'hAA);
		push_pixel(8'h55, 8'hAA, 8'h55);
		drain();

		// random geometries; phases stop anywhere, so geometry often changes mid-frame
		for (int mode = 0; mode < 4; mode++) begin
			set_mode(mode);
			for (int phase = 0; phase < 5; phase++) begin
				case ($urandom_range(3))
					0: begin
						write_reg(CFG_IN_WIDTH, pick_width());
						write_reg(CFG_IN_HEIGHT, pick_height());
					end
					1: write_reg(CFG_IN_WIDTH, pick_width());
					2: write_reg(CFG_IN_HEIGHT, pick_height());
					default: begin
						write_reg(CFG_IN_HEIGHT, pick_height());
						write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(8191)));
						write_reg(CFG_IN_WIDTH, pick_width());
					end
				endcase
				run_pixels($urandom_range(20, 50));
				drain();
			end
		end

		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
